FILE: rtl/b64sd_pkg.sv
// Package: shared types and constants for the strict base64 decoder.
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    localparam logic [7:0] LO_BASE  = 8'd26;
    localparam logic [7:0] DIG_BASE = 8'd52;
    localparam logic [5:0] VAL_PLUS  = 6'd62;
    localparam logic [5:0] VAL_SLASH = 6'd63;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
    localparam logic [1:0] ST_BAD_PAYLOAD = 2'd2;

    // One queued decode job: up to three results from one group.
    typedef struct packed {
        logic [23:0] chunk;
        logic [1:0]  nres;
        logic        has_bytes;
        logic        end_text;
        logic [1:0]  status;
    } job_t;

endpackage

FILE: rtl/b64sd_front.sv
// Front end: character classification, group assembly and error tracking.
`timescale 1ns / 1ps

module b64sd_front
    import b64sd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_last,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    logic [1:0]  slot_reg,  slot_next;
    logic [17:0] acc_reg,   acc_next;
    logic [2:0]  pad_reg,   pad_next;
    logic [1:0]  len_reg,   len_next;
    logic [1:0]  err_reg,   err_next;

    logic        bad;
    logic        err;
    logic [5:0]  v;
    logic [6:0]  sx;
    logic [1:0]  n;
    logic        accept;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r = {1'b1, 6'(c - CH_UP_A)};
        end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            r = {1'b1, 6'(c - CH_LO_A + LO_BASE)};
        end else if (c inside {[CH_DIG_0:CH_DIG_9]}) begin
            r = {1'b1, 6'(c - CH_DIG_0 + DIG_BASE)};
        end else if (c == CH_PLUS) begin
            r = {1'b1, VAL_PLUS};
        end else if (c == CH_SLASH) begin
            r = {1'b1, VAL_SLASH};
        end
        return r;
    endfunction

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign err     = (err_reg != ST_OK);
    assign sx      = sextet_of(s_character);

    always_comb begin
        bad       = 1'b0;
        v         = '0;
        n         = '0;
        pad_next  = pad_reg;
        slot_next = slot_reg;
        acc_next  = acc_reg;
        push      = 1'b0;
        push_job  = '0;

        if (!err) begin
            if (s_character == CH_PAD) begin
                if (pad_reg != 3'd7) begin
                    pad_next = pad_reg + 3'd1;
                end
            end else if (pad_reg != 3'd0) begin
                bad = 1'b1;
            end else if (!sx[6]) begin
                bad = 1'b1;
            end else begin
                v = sx[5:0];
            end
        end

        len_next = len_reg + 2'd1;
        push_job.chunk = {acc_reg, v};

        if (slot_reg != 2'd3) begin
            acc_next  = {acc_reg[11:0], v};
            slot_next = slot_reg + 2'd1;
        end else begin
            if (!err && !bad) begin
                if (pad_next > 3'd2) begin
                    bad = 1'b1;
                end else if (pad_next != 3'd0 && !s_last) begin
                    bad = 1'b1;
                end else begin
                    n = 2'(3'd3 - pad_next);
                end
            end
            slot_next = '0;
            acc_next  = '0;
            pad_next  = '0;
        end

        err_next = bad ? ST_BAD_PAYLOAD : err_reg;

        push_job.nres      = (n != 2'd0) ? n : 2'd1;
        push_job.has_bytes = (n != 2'd0);
        push_job.end_text  = s_last;
        push_job.status    = ST_OK;
        if (s_last) begin
            push_job.status = (len_next != 2'd0) ? ST_BAD_LENGTH : err_next;
            slot_next = '0;
            acc_next  = '0;
            pad_next  = '0;
            len_next  = '0;
            err_next  = ST_OK;
        end
        push = accept && ((n != 2'd0) || s_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            acc_reg  <= '0;
            pad_reg  <= '0;
            len_reg  <= '0;
            err_reg  <= ST_OK;
        end else if (accept) begin
            slot_reg <= slot_next;
            acc_reg  <= acc_next;
            pad_reg  <= pad_next;
            len_reg  <= len_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: rtl/b64sd_queue.sv
// Short job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module b64sd_queue
    import b64sd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/b64sd_back.sv
// Back end: splits each queued job into byte transfers on the output register.
`timescale 1ns / 1ps

module b64sd_back
    import b64sd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       not_empty,
    input  job_t       head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_has_byte,
    output logic       m_end_of_text,
    output logic [1:0] m_status
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       has_reg;
    logic       end_reg;
    logic [1:0] status_reg;

    logic       adv;
    logic       fire;
    logic       final_res;
    logic [7:0] sel_byte;

    assign adv       = !valid_reg || m_ready;
    assign fire      = adv && not_empty;
    assign final_res = (idx_reg == head.nres - 2'd1);
    assign pop       = fire && final_res;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.chunk[23:16];
            2'd1:    sel_byte = head.chunk[15:8];
            default: sel_byte = head.chunk[7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (adv) begin
            valid_reg <= not_empty;
            if (fire) begin
                idx_reg <= final_res ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg   <= head.has_bytes ? sel_byte : 8'd0;
            has_reg    <= head.has_bytes;
            end_reg    <= head.end_text && final_res;
            status_reg <= (head.end_text && final_res) ? head.status : ST_OK;
        end
    end

    assign m_valid       = valid_reg;
    assign m_data_byte   = data_reg;
    assign m_has_byte    = has_reg;
    assign m_end_of_text = end_reg;
    assign m_status      = status_reg;

endmodule

FILE: rtl/base64_strict_decoder.sv
// Top level of the strict base64 decoder.
//
// Input: one character a transfer on s_valid/s_ready, s_last on the final one.
// Output: decoded bytes on m_valid/m_ready; m_has_byte marks a real byte,
// m_end_of_text the final transfer of a text, with m_status (0 ok, 1 bad
// length, 2 bad payload). Bytes of a text whose status is not ok are void.
// A character is taken every cycle while the job queue has room; the front
// end classifies it and queues a job at each error-free group end and at
// the final character. The emitter sends one byte a cycle from the head
// job while m_ready allows, so a group of four characters yields up to
// three bytes; the output port sets the peak rate at one transfer per cycle.
// The first byte of a job passes from the queue entry to the output register.
// A stalled receiver fills the queue (QUEUE_DEPTH jobs), then s_ready drops.
// Synchronous reset (aresetn low) clears group state, queue and output valid.
`timescale 1ns / 1ps

module base64_strict_decoder
    import b64sd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_has_byte,
    output logic       m_end_of_text,
    output logic [1:0] m_status
);

    logic push, pop, full, not_empty;
    job_t push_job, head;

    b64sd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .queue_full  (full),
        .push        (push),
        .push_job    (push_job)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    b64sd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .not_empty     (not_empty),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_has_byte    (m_has_byte),
        .m_end_of_text (m_end_of_text),
        .m_status      (m_status)
    );

endmodule

FILE: rtl/b64sd_checker.sv
// Checker: port-level properties of the decoder output, bound to the top level.
`timescale 1ns / 1ps

module b64sd_checker
    import b64sd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_byte,
    input logic       m_has_byte,
    input logic       m_end_of_text,
    input logic [1:0] m_status
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte))
        else $error("output transfer dropped while stalled");

    a_empty_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_end_of_text && m_data_byte == 8'd0)
        else $error("byteless transfer not at end of text");

    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_text |-> m_status == ST_OK)
        else $error("status set before end of text");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_text |->
            m_status == ST_OK || m_status == ST_BAD_LENGTH || m_status == ST_BAD_PAYLOAD)
        else $error("undefined status code");

endmodule

bind base64_strict_decoder b64sd_checker u_b64sd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_byte   (m_data_byte),
    .m_has_byte    (m_has_byte),
    .m_end_of_text (m_end_of_text),
    .m_status      (m_status)
);
